// ===== sv/lcch_pkg.sv =====
// ----------------------------------------------------------------------------
// lcch_pkg
// Shared types, centroid tables and state encodings of the Lab cell color
// histogram block.
// ----------------------------------------------------------------------------
package lcch_pkg;

  // field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned BinW   = 4;
  localparam int unsigned CountW = 5;

  // centroid table geometry
  localparam int unsigned TableSize = 15;
  localparam int unsigned CenW      = 28;
  localparam int unsigned ProdW     = PixW + CenW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned QW        = 37;
  localparam int unsigned RW        = 21;
  localparam int unsigned TW        = SumW + 1;

  // a distance splits into FixDiv * (quotient - dot product) + remainder
  localparam longint unsigned FixDiv = 64'd2000000;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef logic [CenW-1:0] cen_tab_t [TableSize];
  typedef logic [QW-1:0]   q_tab_t   [TableSize];
  typedef logic [RW-1:0]   r_tab_t   [TableSize];

  // centroids in millionths of a channel step
  localparam cen_tab_t CenL = '{
    28'd161317504, 28'd142922425, 28'd67879757,  28'd92705062,  28'd120172257,
    28'd195470568, 28'd41257102,  28'd12014861,  28'd226567086, 28'd154664210,
    28'd121180447, 28'd87042204,  28'd113809537, 28'd81083293,  28'd45015485
  };
  localparam cen_tab_t CenA = '{
    28'd127223401, 28'd128666965, 28'd127721830, 28'd129965717, 28'd128279647,
    28'd127857070, 28'd130059468, 28'd129480555, 28'd127567831, 28'd131676606,
    28'd137020793, 28'd137211742, 28'd106577104, 28'd170051905, 28'd138543124
  };
  localparam cen_tab_t CenB = '{
    28'd128609333, 28'd127532319, 28'd135903311, 28'd137399500, 28'd127036493,
    28'd129345415, 28'd132675336, 28'd127064714, 28'd136345727, 28'd156481669,
    28'd153433743, 28'd98614874,  28'd157818094, 28'd148904079, 28'd102402528
  };

  // squared norm of one centroid
  function automatic longint unsigned cen_norm(int unsigned idx);
    longint unsigned l;
    longint unsigned a;
    longint unsigned b;
    l = 64'(CenL[idx]);
    a = 64'(CenA[idx]);
    b = 64'(CenB[idx]);
    return l * l + a * a + b * b;
  endfunction

  function automatic q_tab_t build_q();
    q_tab_t tab;
    for (int unsigned i = 0; i < TableSize; i++) begin
      tab[i] = QW'(cen_norm(i) / FixDiv);
    end
    return tab;
  endfunction

  function automatic r_tab_t build_r();
    r_tab_t tab;
    for (int unsigned i = 0; i < TableSize; i++) begin
      tab[i] = RW'(cen_norm(i) % FixDiv);
    end
    return tab;
  endfunction

  localparam q_tab_t CenQ = build_q();
  localparam r_tab_t CenR = build_r();

  // classified pixel handed from front to back
  typedef struct packed {
    logic [BinW-1:0] bin;
    logic            cell_end;
  } class_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SCAN,
    FR_PUSH
  } front_state_e;

  typedef enum logic {
    BK_RUN,
    BK_EMIT
  } back_state_e;

endpackage

// ===== sv/lcch_intf.sv =====
// ----------------------------------------------------------------------------
// lcch channel interfaces
// Valid/ready channels for Lab pixel requests and histogram bin results.
// ----------------------------------------------------------------------------
interface lcch_pix_if;
  logic                        valid;
  logic                        ready;
  logic [lcch_pkg::PixW-1:0]   lightness;
  logic [lcch_pkg::PixW-1:0]   chroma_a;
  logic [lcch_pkg::PixW-1:0]   chroma_b;
  logic                        cell_end;

  modport source (output valid, lightness, chroma_a, chroma_b, cell_end, input ready);
  modport sink   (input valid, lightness, chroma_a, chroma_b, cell_end, output ready);
endinterface

interface lcch_bin_if;
  logic                        valid;
  logic                        ready;
  logic [lcch_pkg::BinW-1:0]   bin_index;
  logic [lcch_pkg::CountW-1:0] bin_count;
  logic                        last_bin;

  modport source (output valid, bin_index, bin_count, last_bin, input ready);
  modport sink   (input valid, bin_index, bin_count, last_bin, output ready);
endinterface

// ===== sv/lcch_front.sv =====
// ----------------------------------------------------------------------------
// lcch_front
// Accepts a pixel and finds its nearest centroid, one centroid per cycle
// through a shared dot-product unit and a two-field compare.
// ----------------------------------------------------------------------------
module lcch_front #(
  parameter int unsigned NUM_CLUSTERS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcch_pix_if.sink         pix_i,
  output lcch_pkg::class_t cls_o,
  output logic             cls_valid_o,
  input  logic             cls_ready_i
);

  localparam int unsigned ActiveBins =
    (NUM_CLUSTERS < lcch_pkg::TableSize) ? NUM_CLUSTERS : lcch_pkg::TableSize;
  localparam logic [lcch_pkg::BinW-1:0] LastBin = lcch_pkg::BinW'(ActiveBins - 1);

  lcch_pkg::front_state_e state_q, state_d;

  logic [lcch_pkg::PixW-1:0]  l_q, a_q, b_q;
  logic                       end_q;
  logic [lcch_pkg::BinW-1:0]  k_q;
  logic                       iss_done_q;
  logic                       issue;
  logic                       accept;

  logic [lcch_pkg::ProdW-1:0] prod_l, prod_a, prod_b;
  logic [lcch_pkg::SumW-1:0]  sum_d, s_q;
  logic [lcch_pkg::BinW-1:0]  sidx_q;
  logic                       s_vld_q;

  logic signed [lcch_pkg::TW-1:0] t_cur, best_t_q;
  logic [lcch_pkg::RW-1:0]        r_cur, best_r_q;
  logic [lcch_pkg::BinW-1:0]      best_q;
  logic                           better;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcch_pkg::FR_IDLE: if (pix_i.valid) state_d = lcch_pkg::FR_SCAN;
      lcch_pkg::FR_SCAN: if (s_vld_q && sidx_q == LastBin) state_d = lcch_pkg::FR_PUSH;
      lcch_pkg::FR_PUSH: if (cls_ready_i) state_d = lcch_pkg::FR_IDLE;
      default:           state_d = lcch_pkg::FR_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pix_i.ready = 1'b0;
    cls_valid_o = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      lcch_pkg::FR_IDLE: pix_i.ready = 1'b1;
      lcch_pkg::FR_SCAN: issue = !iss_done_q;
      lcch_pkg::FR_PUSH: cls_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign accept = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcch_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pixel request latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_q   <= pix_i.lightness;
      a_q   <= pix_i.chroma_a;
      b_q   <= pix_i.chroma_b;
      end_q <= pix_i.cell_end;
    end
  end

  // centroid issue counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      iss_done_q <= 1'b0;
    end else if (accept) begin
      k_q        <= '0;
      iss_done_q <= 1'b0;
    end else if (issue) begin
      if (k_q == LastBin) begin
        iss_done_q <= 1'b1;
      end else begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // dot product of pixel and centroid
  assign prod_l = {{lcch_pkg::CenW{1'b0}}, l_q} * {{lcch_pkg::PixW{1'b0}}, lcch_pkg::CenL[k_q]};
  assign prod_a = {{lcch_pkg::CenW{1'b0}}, a_q} * {{lcch_pkg::PixW{1'b0}}, lcch_pkg::CenA[k_q]};
  assign prod_b = {{lcch_pkg::CenW{1'b0}}, b_q} * {{lcch_pkg::PixW{1'b0}}, lcch_pkg::CenB[k_q]};
  assign sum_d  = lcch_pkg::SumW'(prod_l) + lcch_pkg::SumW'(prod_a) + lcch_pkg::SumW'(prod_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s_q    <= sum_d;
      sidx_q <= k_q;
    end
  end

  // distance key: quotient minus dot product, remainder breaks equal keys
  assign t_cur  = $signed({2'b00, lcch_pkg::CenQ[sidx_q]}) - $signed({1'b0, s_q});
  assign r_cur  = lcch_pkg::CenR[sidx_q];
  assign better = (sidx_q == '0) || (t_cur < best_t_q) ||
                  ((t_cur == best_t_q) && (r_cur < best_r_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (s_vld_q && better) begin
      best_q <= sidx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_vld_q && better) begin
      best_t_q <= t_cur;
      best_r_q <= r_cur;
    end
  end

  assign cls_o.bin      = best_q;
  assign cls_o.cell_end = end_q;

  // checks
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_valid_o |-> best_q <= LastBin)
    else $error("front: winning centroid outside active range");

  a_no_issue_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && k_q == LastBin) |=> !issue)
    else $error("front: centroid issued past the last one");

endmodule

// ===== sv/lcch_fifo.sv =====
// ----------------------------------------------------------------------------
// lcch_fifo
// Short queue of classified pixels between the front and back sections.
// ----------------------------------------------------------------------------
module lcch_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  lcch_pkg::class_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output lcch_pkg::class_t pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  lcch_pkg::class_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("fifo: fill count beyond depth");

endmodule

// ===== sv/lcch_back.sv =====
// ----------------------------------------------------------------------------
// lcch_back
// Counts classified pixels per centroid and, at a cell end, emits the
// scaled histogram through an output register, one bin per cycle when ready.
// ----------------------------------------------------------------------------
module lcch_back #(
  parameter int unsigned NUM_CLUSTERS = 15,
  parameter int unsigned CELL_PIXELS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cls_valid_i,
  input  lcch_pkg::class_t cls_i,
  output logic             cls_ready_o,
  lcch_bin_if.source       bin_o
);

  localparam int unsigned ActiveBins =
    (NUM_CLUSTERS < lcch_pkg::TableSize) ? NUM_CLUSTERS : lcch_pkg::TableSize;
  localparam logic [lcch_pkg::BinW-1:0] LastBin = lcch_pkg::BinW'(ActiveBins - 1);
  localparam int unsigned ScaleEntries = 2 ** lcch_pkg::CountW;

  lcch_pkg::back_state_e state_q, state_d;

  logic [lcch_pkg::CountW-1:0] cnt_q [lcch_pkg::TableSize];
  logic [lcch_pkg::CountW-1:0] cnt_d [lcch_pkg::TableSize];
  logic [lcch_pkg::CountW-1:0] scale_tab [ScaleEntries];

  logic [lcch_pkg::BinW-1:0]   j_q;
  logic                        pop, load, load_last;

  logic                        ovalid_q;
  logic [lcch_pkg::BinW-1:0]   oidx_q;
  logic [lcch_pkg::CountW-1:0] ocount_q;
  logic                        olast_q;

  // count to 1/16 units with rounding, saturated
  for (genvar g = 0; g < ScaleEntries; g++) begin : g_scale
    localparam int unsigned Raw = (g * 16 + CELL_PIXELS / 2) / CELL_PIXELS;
    assign scale_tab[g] = (Raw > lcch_pkg::CountMax) ? lcch_pkg::CountMax
                                                     : lcch_pkg::CountW'(Raw);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcch_pkg::BK_RUN:  if (pop && cls_i.cell_end) state_d = lcch_pkg::BK_EMIT;
      lcch_pkg::BK_EMIT: if (load_last) state_d = lcch_pkg::BK_RUN;
      default:           state_d = lcch_pkg::BK_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    cls_ready_o = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      lcch_pkg::BK_RUN:  cls_ready_o = 1'b1;
      lcch_pkg::BK_EMIT: load = !ovalid_q || bin_o.ready;
      default: ;
    endcase
  end

  assign pop       = cls_valid_i && cls_ready_o;
  assign load_last = load && (j_q == LastBin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcch_pkg::BK_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // per-centroid counters: saturating increment, cleared after the last bin
  always_comb begin
    for (int unsigned i = 0; i < lcch_pkg::TableSize; i++) begin
      cnt_d[i] = cnt_q[i];
      if (load_last) begin
        cnt_d[i] = '0;
      end else if (pop && cls_i.bin == lcch_pkg::BinW'(i) &&
                   cnt_q[i] != lcch_pkg::CountMax) begin
        cnt_d[i] = cnt_q[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < lcch_pkg::TableSize; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // bin walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (load) begin
      j_q <= load_last ? '0 : j_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load) begin
      ovalid_q <= 1'b1;
    end else if (bin_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      oidx_q   <= j_q;
      ocount_q <= scale_tab[cnt_q[j_q]];
      olast_q  <= (j_q == LastBin);
    end
  end

  assign bin_o.valid     = ovalid_q;
  assign bin_o.bin_index = oidx_q;
  assign bin_o.bin_count = ocount_q;
  assign bin_o.last_bin  = olast_q;

  // checks
  a_last_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> oidx_q == LastBin)
    else $error("back: last bin flag on wrong index");

  a_cleared_after_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_last |=> (cnt_q[0] == '0 && state_q == lcch_pkg::BK_RUN))
    else $error("back: counters not cleared after histogram");

endmodule

// ===== sv/lab_cell_color_histogram_top.sv =====
// Each pixel passes through the front in order: it is accepted, one centroid
// per cycle goes through the shared dot-product unit, each registered sum is
// compared against the best so far, and the winner is pushed into the queue.
// A cell end makes the back emit one bin per active centroid, one bin per
// cycle while the receiver keeps ready high, through its output register.
// Reset clears the bin counters, the queue and all handshake state at once.
// ----------------------------------------------------------------------------
// lab_cell_color_histogram_top
// Nearest color centroid per Lab pixel and per-cell histogram of the winners.
// ----------------------------------------------------------------------------
module lab_cell_color_histogram_top #(
  parameter int unsigned NUM_CLUSTERS = 15,
  parameter int unsigned CELL_PIXELS  = 16,
  parameter int unsigned QUEUE_DEPTH  = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcch_pix_if.sink   pix_i,
  lcch_bin_if.source bin_o
);

  lcch_pkg::class_t front_cls, back_cls;
  logic             front_valid, front_ready;
  logic             back_valid, back_ready;

  // pixel classification
  lcch_front #(
    .NUM_CLUSTERS(NUM_CLUSTERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cls_o       (front_cls),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready)
  );

  // decoupling queue
  lcch_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_cls),
    .push_ready_o (front_ready),
    .pop_valid_o  (back_valid),
    .pop_data_o   (back_cls),
    .pop_ready_i  (back_ready)
  );

  // histogram and result emission
  lcch_back #(
    .NUM_CLUSTERS(NUM_CLUSTERS),
    .CELL_PIXELS (CELL_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (back_valid),
    .cls_i       (back_cls),
    .cls_ready_o (back_ready),
    .bin_o       (bin_o)
  );

endmodule
